### hdl/rtcc_pkg.sv
// ----------------------------------------------------------------------------
// rtcc_pkg
// Shared types and register codes for the real-time compare counter.
// ----------------------------------------------------------------------------
package rtcc_pkg;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2
   } req_kind_type;

   // fixed register codes; the rest follow from the channel count
   localparam logic [4:0] REG_START  = 5'd0;
   localparam logic [4:0] REG_STOP   = 5'd1;
   localparam logic [4:0] REG_CLEAR  = 5'd2;
   localparam logic [4:0] REG_TRIG   = 5'd3;
   localparam logic [4:0] REG_EVTICK = 5'd4;
   localparam logic [4:0] REG_EVOVF  = 5'd5;
   localparam logic [4:0] REG_EVCMP  = 5'd6;

   // offsets past the compare event words
   localparam int OFS_INTENSET  = 0;
   localparam int OFS_INTENCLR  = 1;
   localparam int OFS_EVTEN     = 2;
   localparam int OFS_EVTENSET  = 3;
   localparam int OFS_EVTENCLR  = 4;
   localparam int OFS_COUNTER   = 5;
   localparam int OFS_PRESCALER = 6;
   localparam int OFS_CC        = 7;

   localparam int EN_TICK_BIT = 0;
   localparam int EN_OVF_BIT  = 1;
   localparam int EN_CMP_BIT  = 16;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  reg_index;
      logic [31:0] write_data;
   } request_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_pulse;
      logic        notify_pulse;
      logic        bad_write;
   } result_type;

endpackage

### hdl/rtcc_in_reg.sv
// ----------------------------------------------------------------------------
// rtcc_in_reg
// Input register: holds one request transaction until the engine takes it.
// ----------------------------------------------------------------------------
module rtcc_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rtcc_pkg::request_type req_in,
   input  logic                  advance,
   output logic                  stage_valid,
   output rtcc_pkg::request_type stage_req
);

   logic                  valid_ff;
   logic                  valid_in;
   rtcc_pkg::request_type req_ff;
   logic                  take;

   assign req_ready   = !valid_ff || advance;
   assign take        = req_valid && req_ready;
   assign valid_in    = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
   assign stage_valid = valid_ff;
   assign stage_req   = req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_in;
      end
   end

endmodule

### hdl/rtcc_engine.sv
// ----------------------------------------------------------------------------
// rtcc_engine
// Register file, counter, prescaler and event logic; one transaction per go.
// ----------------------------------------------------------------------------
module rtcc_engine #(
   parameter int COUNT_BITS       = 24,
   parameter int COMPARE_CHANNELS = 4,
   parameter int PRESCALE_MAX     = 4095
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  rtcc_pkg::request_type req,
   output rtcc_pkg::result_type  result
);

   localparam int CH = COMPARE_CHANNELS;
   localparam int PW = $clog2(PRESCALE_MAX + 1);
   localparam int BASE = int'(rtcc_pkg::REG_EVCMP) + CH;
   localparam logic [4:0] R_INTENSET  = 5'(BASE + rtcc_pkg::OFS_INTENSET);
   localparam logic [4:0] R_INTENCLR  = 5'(BASE + rtcc_pkg::OFS_INTENCLR);
   localparam logic [4:0] R_EVTEN     = 5'(BASE + rtcc_pkg::OFS_EVTEN);
   localparam logic [4:0] R_EVTENSET  = 5'(BASE + rtcc_pkg::OFS_EVTENSET);
   localparam logic [4:0] R_EVTENCLR  = 5'(BASE + rtcc_pkg::OFS_EVTENCLR);
   localparam logic [4:0] R_COUNTER   = 5'(BASE + rtcc_pkg::OFS_COUNTER);
   localparam logic [4:0] R_PRESCALER = 5'(BASE + rtcc_pkg::OFS_PRESCALER);
   localparam int         R_CC        = BASE + rtcc_pkg::OFS_CC;
   localparam int         NREGS       = R_CC + CH;
   localparam logic [COUNT_BITS-1:0] COUNT_ALL  = '1;
   localparam logic [COUNT_BITS-1:0] TRIG_VALUE = {{(COUNT_BITS-4){1'b1}}, 4'b0000};
   localparam logic [31:0] PMAX32 = 32'(PRESCALE_MAX);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [31:0] start_ff, start_in, stop_ff, stop_in;
   logic [31:0] clear_ff, clear_in, trig_ff, trig_in;
   logic [31:0] evtick_ff, evtick_in, evovf_ff, evovf_in;
   logic [31:0] evcmp_ff [CH];
   logic [31:0] evcmp_in [CH];
   logic [31:0] cc_ff [CH];
   logic [31:0] cc_in [CH];
   logic [31:0] emask_ff, emask_in, imask_ff, imask_in;
   logic [31:0] evtenset_ff, evtenset_in, evtenclr_ff, evtenclr_in;
   logic [PW-1:0] presc_ff, presc_in, pcount_ff, pcount_in;
   logic armed_ff, armed_in, clrreq_ff, clrreq_in, skip_ff, skip_in;

   always_comb begin
      logic [4:0]  idx;
      logic [31:0] data;
      logic [31:0] rd;
      logic        irq, notify, bad, running, armed_n;
      rtcc_pkg::req_kind_type kind;

      idx  = req.reg_index;
      data = req.write_data;
      kind = rtcc_pkg::req_kind_type'(req.kind);
      rd = '0;
      irq = 1'b0;
      notify = 1'b0;
      bad = 1'b0;
      running = !((stop_ff != '0) && (start_ff == '0));
      armed_n = armed_ff;

      count_in = count_ff;
      start_in = start_ff;
      stop_in = stop_ff;
      clear_in = clear_ff;
      trig_in = trig_ff;
      evtick_in = evtick_ff;
      evovf_in = evovf_ff;
      evcmp_in = evcmp_ff;
      cc_in = cc_ff;
      emask_in = emask_ff;
      imask_in = imask_ff;
      evtenset_in = evtenset_ff;
      evtenclr_in = evtenclr_ff;
      presc_in = presc_ff;
      pcount_in = pcount_ff;
      armed_in = armed_ff;
      clrreq_in = clrreq_ff;
      skip_in = skip_ff;

      case (kind)
         rtcc_pkg::KIND_TICK: begin
            if (running) begin
               if (pcount_ff >= presc_ff) begin
                  pcount_in = '0;
                  if (emask_ff[rtcc_pkg::EN_OVF_BIT] && (count_ff == COUNT_ALL)) begin
                     armed_n = 1'b1;
                  end
                  if (emask_ff[rtcc_pkg::EN_TICK_BIT]) begin
                     evtick_in = 32'd1;
                     if (imask_ff[rtcc_pkg::EN_TICK_BIT]) begin
                        irq = 1'b1;
                     end
                  end
                  if (armed_n && (count_ff == '0) && !skip_ff) begin
                     evovf_in = 32'd1;
                     notify = 1'b1;
                     if (imask_ff[rtcc_pkg::EN_OVF_BIT]) begin
                        irq = 1'b1;
                     end
                     armed_n = 1'b0;
                  end
                  for (int i = 0; i < CH; i++) begin
                     if (emask_ff[rtcc_pkg::EN_CMP_BIT + i] && !skip_ff &&
                         (cc_ff[i] == 32'(count_ff))) begin
                        evcmp_in[i] = 32'd1;
                        notify = 1'b1;
                        if (imask_ff[rtcc_pkg::EN_CMP_BIT + i]) begin
                           irq = 1'b1;
                        end
                     end
                  end
                  armed_in = armed_n;
                  count_in = clrreq_ff ? '0 : count_ff + 1'b1;
                  skip_in = clrreq_ff;
                  clrreq_in = 1'b0;
                  clear_in = '0;
               end else begin
                  pcount_in = pcount_ff + 1'b1;
               end
            end
         end
         rtcc_pkg::KIND_READ: begin
            if (idx == rtcc_pkg::REG_START) rd = start_ff;
            if (idx == rtcc_pkg::REG_STOP) rd = stop_ff;
            if (idx == rtcc_pkg::REG_CLEAR) rd = clear_ff;
            if (idx == rtcc_pkg::REG_TRIG) rd = trig_ff;
            if (idx == rtcc_pkg::REG_EVTICK) rd = evtick_ff;
            if (idx == rtcc_pkg::REG_EVOVF) rd = evovf_ff;
            if (idx == R_INTENSET || idx == R_INTENCLR) rd = imask_ff;
            if (idx == R_EVTEN) rd = emask_ff;
            if (idx == R_EVTENSET) rd = evtenset_ff;
            if (idx == R_EVTENCLR) rd = evtenclr_ff;
            if (idx == R_COUNTER) rd = 32'(count_ff);
            if (idx == R_PRESCALER) rd = 32'(presc_ff);
            for (int i = 0; i < CH; i++) begin
               if (idx == 5'(int'(rtcc_pkg::REG_EVCMP) + i)) rd = evcmp_ff[i];
               if (idx == 5'(R_CC + i)) rd = cc_ff[i];
            end
         end
         rtcc_pkg::KIND_WRITE: begin
            if (int'(idx) < NREGS) begin
               if (idx == rtcc_pkg::REG_START) begin
                  start_in = data;
                  if (data != '0) stop_in = '0;
               end
               if (idx == rtcc_pkg::REG_STOP) begin
                  stop_in = data;
                  if (data != '0) start_in = '0;
               end
               if (idx == rtcc_pkg::REG_CLEAR) begin
                  clear_in = data;
                  clrreq_in = 1'b1;
               end
               if (idx == rtcc_pkg::REG_TRIG) begin
                  trig_in = data;
                  count_in = TRIG_VALUE;
               end
               if (idx == rtcc_pkg::REG_EVTICK) begin
                  evtick_in = data;
                  notify = 1'b1;
               end
               if (idx == rtcc_pkg::REG_EVOVF) begin
                  evovf_in = data;
                  notify = 1'b1;
               end
               for (int i = 0; i < CH; i++) begin
                  if (idx == 5'(int'(rtcc_pkg::REG_EVCMP) + i)) begin
                     evcmp_in[i] = data;
                     notify = 1'b1;
                  end
                  if (idx == 5'(R_CC + i)) cc_in[i] = data;
               end
               if (idx == R_INTENSET) imask_in = imask_ff | data;
               if (idx == R_INTENCLR) imask_in = imask_ff & ~data;
               if (idx == R_EVTEN) emask_in = data;
               if (idx == R_EVTENSET) begin
                  evtenset_in = data;
                  emask_in = emask_ff | data;
               end
               if (idx == R_EVTENCLR) begin
                  evtenclr_in = data;
                  emask_in = emask_ff & ~data;
               end
               if (idx == R_PRESCALER) begin
                  if (data > PMAX32) bad = 1'b1;
                  else presc_in = PW'(data);
               end
            end
         end
         default: begin
         end
      endcase

      result.read_data    = rd;
      result.irq_pulse    = irq;
      result.notify_pulse = notify;
      result.bad_write    = bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         start_ff <= '0;
         stop_ff <= 32'd1;
         clear_ff <= '0;
         trig_ff <= '0;
         evtick_ff <= '0;
         evovf_ff <= '0;
         for (int i = 0; i < CH; i++) begin
            evcmp_ff[i] <= '0;
            cc_ff[i] <= '0;
         end
         emask_ff <= '0;
         imask_ff <= '0;
         evtenset_ff <= '0;
         evtenclr_ff <= '0;
         presc_ff <= '0;
         pcount_ff <= '0;
         armed_ff <= 1'b0;
         clrreq_ff <= 1'b0;
         skip_ff <= 1'b0;
      end else if (go) begin
         count_ff <= count_in;
         start_ff <= start_in;
         stop_ff <= stop_in;
         clear_ff <= clear_in;
         trig_ff <= trig_in;
         evtick_ff <= evtick_in;
         evovf_ff <= evovf_in;
         evcmp_ff <= evcmp_in;
         cc_ff <= cc_in;
         emask_ff <= emask_in;
         imask_ff <= imask_in;
         evtenset_ff <= evtenset_in;
         evtenclr_ff <= evtenclr_in;
         presc_ff <= presc_in;
         pcount_ff <= pcount_in;
         armed_ff <= armed_in;
         clrreq_ff <= clrreq_in;
         skip_ff <= skip_in;
      end
   end

endmodule

### hdl/rtcc_out_reg.sv
// ----------------------------------------------------------------------------
// rtcc_out_reg
// Result register: holds one response transaction until it is taken.
// ----------------------------------------------------------------------------
module rtcc_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  rtcc_pkg::result_type result_in,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rtcc_pkg::result_type rsp_out
);

   logic                 valid_ff;
   logic                 valid_in;
   rtcc_pkg::result_type result_ff;

   assign room      = !valid_ff || rsp_ready;
   assign valid_in  = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   assign rsp_valid = valid_ff;
   assign rsp_out   = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

endmodule

### hdl/rtc_compare_counter_core.sv
// ----------------------------------------------------------------------------
// rtc_compare_counter_core
// Real-time counter with compare channels, prescaler and event/interrupt masks.
//
//   channel   direction   ports
//   req       in          req_valid/req_ready, req_type, req_reg_index,
//                         req_write_data
//   rsp       out         rsp_valid/rsp_ready, rsp_read_data, rsp_irq_pulse,
//                         rsp_notify_pulse, rsp_bad_write
//
// A request passes through the input register, then the result register.
// One transaction per cycle sustained while the response is not stalled; the
// engine updates state as it loads the result register.
// Reset clears the valid flags and all engine state; the stop word resets to one.
// A stalled response holds the input register, which then drops req_ready.
// ----------------------------------------------------------------------------
module rtc_compare_counter_core #(
   parameter int COUNT_BITS       = 24,
   parameter int COMPARE_CHANNELS = 4,
   parameter int PRESCALE_MAX     = 4095
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [4:0]  req_reg_index,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_pulse,
   output logic        rsp_notify_pulse,
   output logic        rsp_bad_write
);

   rtcc_pkg::request_type req_in;
   rtcc_pkg::request_type stage_req;
   rtcc_pkg::result_type  result;
   rtcc_pkg::result_type  rsp_out;
   logic                  stage_valid;
   logic                  room;
   logic                  advance;

   assign req_in.kind       = req_type;
   assign req_in.reg_index  = req_reg_index;
   assign req_in.write_data = req_write_data;
   assign advance           = stage_valid && room;

   rtcc_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in      (req_in),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_req   (stage_req)
   );

   rtcc_engine #(
      .COUNT_BITS       (COUNT_BITS),
      .COMPARE_CHANNELS (COMPARE_CHANNELS),
      .PRESCALE_MAX     (PRESCALE_MAX)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .go     (advance),
      .req    (stage_req),
      .result (result)
   );

   rtcc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result_in (result),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_out   (rsp_out)
   );

   assign rsp_read_data    = rsp_out.read_data;
   assign rsp_irq_pulse    = rsp_out.irq_pulse;
   assign rsp_notify_pulse = rsp_out.notify_pulse;
   assign rsp_bad_write    = rsp_out.bad_write;

endmodule

### verif/rtcc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtcc_checker
// Watches the request and response channels of the compare counter, keeps its
// own copy of the counter and register state, predicts one response for each
// accepted request and compares responses in order, field by field.
// ----------------------------------------------------------------------------
module rtcc_checker #(
   parameter int CMP_CH         = 4,
   parameter int COUNT_W        = 24,
   parameter int PRESCALE_LIMIT = 4095
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [4:0]  req_reg_index,
   input  logic [31:0] req_write_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_read_data,
   input  logic        rsp_irq_pulse,
   input  logic        rsp_notify_pulse,
   input  logic        rsp_bad_write,
   output int          errors,
   output int          pending
);

   localparam logic [4:0] REG_BASE      = rtcc_pkg::REG_EVCMP + 5'(CMP_CH);
   localparam logic [4:0] REG_INTENSET  = REG_BASE + 5'(rtcc_pkg::OFS_INTENSET);
   localparam logic [4:0] REG_INTENCLR  = REG_BASE + 5'(rtcc_pkg::OFS_INTENCLR);
   localparam logic [4:0] REG_EVTEN     = REG_BASE + 5'(rtcc_pkg::OFS_EVTEN);
   localparam logic [4:0] REG_EVTENSET  = REG_BASE + 5'(rtcc_pkg::OFS_EVTENSET);
   localparam logic [4:0] REG_EVTENCLR  = REG_BASE + 5'(rtcc_pkg::OFS_EVTENCLR);
   localparam logic [4:0] REG_COUNTER   = REG_BASE + 5'(rtcc_pkg::OFS_COUNTER);
   localparam logic [4:0] REG_PRESCALER = REG_BASE + 5'(rtcc_pkg::OFS_PRESCALER);
   localparam logic [4:0] REG_CC        = REG_BASE + 5'(rtcc_pkg::OFS_CC);
   localparam int         NUM_REGS      = REG_CC + CMP_CH;

   logic [COUNT_W-1:0]   count_q;
   logic [31:0]          reg_words [NUM_REGS];
   logic [31:0]          evt_en;
   logic [31:0]          int_en;
   logic                 ovf_armed;
   logic                 clear_pend;
   logic                 skip_cmp;
   logic [31:0]          pre_cnt;
   rtcc_pkg::result_type results_due [$];

   function automatic void step_counter(inout logic irq, inout logic notify);
      if (evt_en[rtcc_pkg::EN_OVF_BIT] && count_q == '1)
         ovf_armed = 1'b1;
      if (evt_en[rtcc_pkg::EN_TICK_BIT]) begin
         reg_words[rtcc_pkg::REG_EVTICK] = 32'd1;
         if (int_en[rtcc_pkg::EN_TICK_BIT])
            irq = 1'b1;
      end
      if (ovf_armed && count_q == '0 && !skip_cmp) begin
         reg_words[rtcc_pkg::REG_EVOVF] = 32'd1;
         notify = 1'b1;
         if (int_en[rtcc_pkg::EN_OVF_BIT])
            irq = 1'b1;
         ovf_armed = 1'b0;
      end
      for (int ch = 0; ch < CMP_CH; ch++) begin
         if (evt_en[rtcc_pkg::EN_CMP_BIT + ch] && !skip_cmp &&
             reg_words[REG_CC + ch] == 32'(count_q)) begin
            reg_words[rtcc_pkg::REG_EVCMP + ch] = 32'd1;
            notify = 1'b1;
            if (int_en[rtcc_pkg::EN_CMP_BIT + ch])
               irq = 1'b1;
         end
      end
      count_q = count_q + 1'b1;
      if (clear_pend) begin
         clear_pend = 1'b0;
         count_q = '0;
         skip_cmp = 1'b1;
      end else begin
         skip_cmp = 1'b0;
      end
      reg_words[rtcc_pkg::REG_CLEAR] = '0;
   endfunction

   function automatic rtcc_pkg::result_type apply_request(logic [1:0] kind, logic [4:0] idx,
                                                          logic [31:0] data);
      rtcc_pkg::result_type res;
      logic                 irq;
      logic                 notify;
      res = '0;
      irq = 1'b0;
      notify = 1'b0;
      case (kind)
         rtcc_pkg::KIND_TICK: begin
            if (!(reg_words[rtcc_pkg::REG_STOP] != 0 && reg_words[rtcc_pkg::REG_START] == 0))
            begin
               if (pre_cnt >= reg_words[REG_PRESCALER]) begin
                  pre_cnt = '0;
                  step_counter(irq, notify);
               end else begin
                  pre_cnt = pre_cnt + 32'd1;
               end
            end
         end
         rtcc_pkg::KIND_READ: begin
            if (idx < NUM_REGS) begin
               if (idx == REG_COUNTER)
                  reg_words[REG_COUNTER] = 32'(count_q);
               res.read_data = reg_words[idx];
            end
         end
         rtcc_pkg::KIND_WRITE: begin
            if (idx < NUM_REGS) begin
               if (idx == REG_PRESCALER && data > PRESCALE_LIMIT)
                  res.bad_write = 1'b1;
               else
                  reg_words[idx] = data;
               if (idx == rtcc_pkg::REG_START && data != 0)
                  reg_words[rtcc_pkg::REG_STOP] = '0;
               else if (idx == rtcc_pkg::REG_STOP && data != 0)
                  reg_words[rtcc_pkg::REG_START] = '0;
               else if (idx == rtcc_pkg::REG_CLEAR)
                  clear_pend = 1'b1;
               else if (idx == rtcc_pkg::REG_TRIG)
                  count_q = {{(COUNT_W - 4){1'b1}}, 4'h0};
               else if (idx >= rtcc_pkg::REG_EVTICK && idx < REG_INTENSET)
                  notify = 1'b1;
               else if (idx == REG_EVTEN)
                  evt_en = data;
               else if (idx == REG_EVTENSET)
                  evt_en = evt_en | data;
               else if (idx == REG_EVTENCLR)
                  evt_en = evt_en & ~data;
               else if (idx == REG_INTENSET || idx == REG_INTENCLR) begin
                  if (idx == REG_INTENSET)
                     int_en = int_en | data;
                  else
                     int_en = int_en & ~data;
                  reg_words[REG_INTENSET] = int_en;
                  reg_words[REG_INTENCLR] = int_en;
               end
               reg_words[REG_EVTEN] = evt_en;
            end
         end
         default: ;
      endcase
      res.irq_pulse = irq;
      res.notify_pulse = notify;
      return res;
   endfunction

   always @(posedge clock) begin
      rtcc_pkg::result_type want;
      if (reset) begin
         count_q = '0;
         foreach (reg_words[i])
            reg_words[i] = '0;
         reg_words[rtcc_pkg::REG_STOP] = 32'd1;
         evt_en = '0;
         int_en = '0;
         ovf_armed = 1'b0;
         clear_pend = 1'b0;
         skip_cmp = 1'b0;
         pre_cnt = '0;
         results_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $error("response transaction with no request outstanding");
               errors++;
            end else begin
               want = results_due.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
                  errors++;
               end
               if (rsp_irq_pulse !== want.irq_pulse) begin
                  $error("irq_pulse: expected %b, got %b", want.irq_pulse, rsp_irq_pulse);
                  errors++;
               end
               if (rsp_notify_pulse !== want.notify_pulse) begin
                  $error("notify_pulse: expected %b, got %b", want.notify_pulse,
                         rsp_notify_pulse);
                  errors++;
               end
               if (rsp_bad_write !== want.bad_write) begin
                  $error("bad_write: expected %b, got %b", want.bad_write, rsp_bad_write);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            results_due.push_back(apply_request(req_type, req_reg_index, req_write_data));
      end
      pending = results_due.size();
   end

endmodule

### verif/rtc_compare_counter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtc_compare_counter_core_tb
// Drives ticks, register reads and register writes into the compare counter:
// a directed pass over the prescaler limits, start/stop, clear and overflow,
// then random traffic of single items mixed with overflow and compare runs, with random
// request gaps and response stalls. The checker module does all comparison.
// ----------------------------------------------------------------------------
module rtc_compare_counter_core_tb;

   localparam int         CMP_CH       = 4;
   localparam int         RANDOM_ITEMS = 2000;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   localparam logic [4:0] REG_BASE      = rtcc_pkg::REG_EVCMP + 5'(CMP_CH);
   localparam logic [4:0] REG_INTENSET  = REG_BASE + 5'(rtcc_pkg::OFS_INTENSET);
   localparam logic [4:0] REG_INTENCLR  = REG_BASE + 5'(rtcc_pkg::OFS_INTENCLR);
   localparam logic [4:0] REG_EVTEN     = REG_BASE + 5'(rtcc_pkg::OFS_EVTEN);
   localparam logic [4:0] REG_EVTENSET  = REG_BASE + 5'(rtcc_pkg::OFS_EVTENSET);
   localparam logic [4:0] REG_EVTENCLR  = REG_BASE + 5'(rtcc_pkg::OFS_EVTENCLR);
   localparam logic [4:0] REG_COUNTER   = REG_BASE + 5'(rtcc_pkg::OFS_COUNTER);
   localparam logic [4:0] REG_PRESCALER = REG_BASE + 5'(rtcc_pkg::OFS_PRESCALER);
   localparam logic [4:0] REG_CC        = REG_BASE + 5'(rtcc_pkg::OFS_CC);
   localparam int         NUM_REGS      = REG_CC + CMP_CH;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_type;
   logic [4:0]  req_reg_index;
   logic [31:0] req_write_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_data;
   logic        rsp_irq_pulse;
   logic        rsp_notify_pulse;
   logic        rsp_bad_write;
   int          fail_count;
   int          due_count;

   int          gap_odds;
   int          stall_odds;
   int          items_done;
   logic [31:0] run_start_word;
   logic [31:0] run_stop_word;

   rtc_compare_counter_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_reg_index   (req_reg_index),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq_pulse   (rsp_irq_pulse),
      .rsp_notify_pulse(rsp_notify_pulse),
      .rsp_bad_write   (rsp_bad_write)
   );

   rtcc_checker #(.CMP_CH(CMP_CH)) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_reg_index   (req_reg_index),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq_pulse   (rsp_irq_pulse),
      .rsp_notify_pulse(rsp_notify_pulse),
      .rsp_bad_write   (rsp_bad_write),
      .errors          (fail_count),
      .pending         (due_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("TB_ERROR");
      $finish;
   end

   // response side: random stall bursts
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(posedge clock);
         if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic [1:0] kind, input logic [4:0] idx,
                            input logic [31:0] data);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_reg_index  <= idx;
      req_write_data <= data;
      do @(posedge clock); while (!req_ready);
      // ticks while stopped and writes outside the map have no effect
      if ((kind == rtcc_pkg::KIND_TICK && !(run_stop_word != 0 && run_start_word == 0)) ||
          kind == rtcc_pkg::KIND_READ || (kind == rtcc_pkg::KIND_WRITE && idx < NUM_REGS))
         items_done++;
      if (kind == rtcc_pkg::KIND_WRITE && idx == rtcc_pkg::REG_START) begin
         run_start_word = data;
         if (data != 0)
            run_stop_word = '0;
      end else if (kind == rtcc_pkg::KIND_WRITE && idx == rtcc_pkg::REG_STOP) begin
         run_stop_word = data;
         if (data != 0)
            run_start_word = '0;
      end
   endtask

   initial begin
      int          first_random;
      int          iter;
      int          pick;
      int          ch;
      int          n;
      logic [4:0]  widx;
      logic [31:0] wdata;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = rtcc_pkg::KIND_TICK;
      req_reg_index  = '0;
      req_write_data = '0;
      gap_odds       = 4;
      stall_odds     = 4;
      items_done     = 0;
      run_start_word = '0;
      run_stop_word  = 32'd1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed
      send_item(rtcc_pkg::KIND_READ, rtcc_pkg::REG_STOP, '0);
      send_item(rtcc_pkg::KIND_TICK, '0, '0);
      send_item(rtcc_pkg::KIND_WRITE, REG_PRESCALER, 32'hFFFF_FFFF);
      send_item(rtcc_pkg::KIND_WRITE, REG_PRESCALER, 32'd4096);
      send_item(rtcc_pkg::KIND_WRITE, REG_PRESCALER, 32'd4095);
      send_item(rtcc_pkg::KIND_WRITE, REG_PRESCALER, 32'd0);
      send_item(rtcc_pkg::KIND_WRITE, rtcc_pkg::REG_START, 32'hFFFF_FFFF);
      send_item(rtcc_pkg::KIND_WRITE, REG_EVTENSET, 32'hFFFF_FFFF);
      send_item(rtcc_pkg::KIND_WRITE, REG_INTENSET, 32'hFFFF_FFFF);
      send_item(rtcc_pkg::KIND_WRITE, rtcc_pkg::REG_TRIG, '0);
      repeat (17) send_item(rtcc_pkg::KIND_TICK, '1, '1);
      send_item(rtcc_pkg::KIND_WRITE, rtcc_pkg::REG_CLEAR, '0);
      send_item(rtcc_pkg::KIND_TICK, '0, '0);
      send_item(rtcc_pkg::KIND_TICK, '0, '0);
      send_item(rtcc_pkg::KIND_WRITE, rtcc_pkg::REG_EVCMP, 32'd1);
      send_item(rtcc_pkg::KIND_READ, REG_COUNTER, '0);
      send_item(rtcc_pkg::KIND_WRITE, 5'd31, 32'hFFFF_FFFF);
      send_item(KIND_UNUSED, 5'd31, 32'hFFFF_FFFF);

      // random
      first_random = items_done;
      iter = 0;
      while (items_done - first_random < RANDOM_ITEMS) begin
         if (items_done - first_random > RANDOM_ITEMS - 300) begin
            gap_odds = 0;
            stall_odds = 0;
         end else if (iter % 150 == 0) begin
            case ($urandom_range(0, 3))
               0: gap_odds = 0;
               1: gap_odds = 2;
               2: gap_odds = 6;
               default: gap_odds = 25;
            endcase
            case ($urandom_range(0, 3))
               0: stall_odds = 0;
               1: stall_odds = 2;
               2: stall_odds = 6;
               default: stall_odds = 25;
            endcase
         end
         iter++;
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // run through the top of the count into overflow
            if ($urandom_range(0, 1) == 1)
               send_item(rtcc_pkg::KIND_WRITE, REG_EVTENSET, 32'h0000_0002);
            send_item(rtcc_pkg::KIND_WRITE, rtcc_pkg::REG_TRIG, $urandom());
            n = $urandom_range(17, 21);
            repeat (n)
               send_item(rtcc_pkg::KIND_TICK, 5'($urandom_range(0, 31)), $urandom());
         end else if (pick < 14) begin
            // compare just after a clear
            ch = $urandom_range(0, CMP_CH - 1);
            n = $urandom_range(0, 6);
            send_item(rtcc_pkg::KIND_WRITE, 5'(REG_CC + ch), 32'(n));
            send_item(rtcc_pkg::KIND_WRITE, REG_EVTENSET, 32'd1 << (rtcc_pkg::EN_CMP_BIT + ch));
            send_item(rtcc_pkg::KIND_WRITE, rtcc_pkg::REG_CLEAR, $urandom());
            repeat (n + 3)
               send_item(rtcc_pkg::KIND_TICK, 5'($urandom_range(0, 31)), $urandom());
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 48) begin
               send_item(rtcc_pkg::KIND_TICK, 5'($urandom_range(0, 31)), $urandom());
            end else if (pick < 63) begin
               widx = ($urandom_range(0, 99) < 92) ? 5'($urandom_range(0, NUM_REGS - 1))
                                                   : 5'($urandom_range(NUM_REGS, 31));
               send_item(rtcc_pkg::KIND_READ, widx, $urandom());
            end else if (pick < 98) begin
               pick = $urandom_range(0, 99);
               if (pick < 20)      widx = 5'(REG_CC + $urandom_range(0, CMP_CH - 1));
               else if (pick < 28) widx = REG_EVTENSET;
               else if (pick < 32) widx = REG_EVTENCLR;
               else if (pick < 35) widx = REG_EVTEN;
               else if (pick < 40) widx = REG_INTENSET;
               else if (pick < 43) widx = REG_INTENCLR;
               else if (pick < 49) widx = rtcc_pkg::REG_CLEAR;
               else if (pick < 54) widx = rtcc_pkg::REG_TRIG;
               else if (pick < 62) widx = rtcc_pkg::REG_START;
               else if (pick < 64) widx = rtcc_pkg::REG_STOP;
               else if (pick < 72) widx = REG_PRESCALER;
               else if (pick < 81)
                  widx = 5'(rtcc_pkg::REG_EVTICK + $urandom_range(0, CMP_CH + 1));
               else if (pick < 85) widx = REG_COUNTER;
               else if (pick < 88) widx = 5'($urandom_range(NUM_REGS, 31));
               else                widx = 5'($urandom_range(0, NUM_REGS - 1));

               wdata = $urandom();
               if (widx >= REG_CC && widx < NUM_REGS) begin
                  case ($urandom_range(0, 2))
                     0: wdata = $urandom_range(0, 40);
                     1: wdata = 32'h00FF_FFF0 + $urandom_range(0, 15);
                     default: ;
                  endcase
               end else if (widx >= REG_INTENSET && widx <= REG_EVTENCLR) begin
                  if ($urandom_range(0, 3) != 0)
                     wdata = ($urandom_range(0, 15) << rtcc_pkg::EN_CMP_BIT) |
                             $urandom_range(0, 3);
               end else if (widx == REG_PRESCALER) begin
                  case ($urandom_range(0, 9))
                     0, 1, 2, 3, 4: wdata = 32'd0;
                     5: wdata = $urandom_range(1, 3);
                     6: wdata = 32'd4095;
                     7: wdata = $urandom_range(0, 4095);
                     8: wdata = 32'd4096;
                     default: ;
                  endcase
               end else if (widx == rtcc_pkg::REG_START || widx == rtcc_pkg::REG_STOP) begin
                  if ($urandom_range(0, 9) == 0)
                     wdata = '0;
               end
               send_item(rtcc_pkg::KIND_WRITE, widx, wdata);
            end else begin
               send_item(KIND_UNUSED, 5'($urandom_range(0, 31)), $urandom());
            end
         end
      end
      req_valid <= 1'b0;

      while (due_count != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
